### src/gbn_pkg.sv
// Shared types, codes and widths for the go-back-n sender.
`timescale 1ns / 1ps

package gbn_pkg;

    localparam int SEQ_W        = 16;
    localparam int BASE_W       = SEQ_W + 1;
    localparam int WIN_W        = 5;
    localparam int PKT_W        = 16;
    localparam int RETRY_W      = 8;
    localparam int OP_W         = 2;
    localparam int STAT_W       = 2;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 16;
    localparam int IN_DATA_W    = 16;
    localparam int OUT_DATA_W   = 56;
    localparam int WINDOW_MAX_DEF = 16;

    localparam logic [WIN_W-1:0]   WINDOW_SIZE_RST  = WIN_W'(3);
    localparam logic [PKT_W-1:0]   PACKET_COUNT_RST = PKT_W'(5);
    localparam logic [RETRY_W-1:0] MAX_RETRIES_RST  = RETRY_W'(5);

    typedef enum logic [OP_W-1:0] {
        OP_START   = 2'd0,
        OP_ACK     = 2'd1,
        OP_TIMEOUT = 2'd2,
        OP_SPARE   = 2'd3
    } op_t;

    typedef enum logic [STAT_W-1:0] {
        ST_RUNNING = 2'd0,
        ST_DONE    = 2'd1,
        ST_ABORTED = 2'd2,
        ST_SPARE   = 2'd3
    } status_code_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WINDOW_SIZE  = 2'd0,
        REG_PACKET_COUNT = 2'd1,
        REG_MAX_RETRIES  = 2'd2,
        REG_SPARE        = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic latch_in;
        logic apply_event;
        logic load_limit;
        logic emit_send;
        logic emit_status;
    } cmd_t;

    typedef struct packed {
        logic skip;
        logic has_send;
        logic last_send;
        logic slot_free;
    } dp_status_t;

endpackage

### src/gbn_ctrl.sv
// Event sequencer for the go-back-n sender.
`timescale 1ns / 1ps

module gbn_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  gbn_pkg::dp_status_t sts,
    output gbn_pkg::cmd_t      cmd
);
    import gbn_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_EVENT = 4'b0010,
        S_LIMIT = 4'b0100,
        S_EMIT  = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.latch_in = 1'b1;
                    state_next   = S_EVENT;
                end
            end
            S_EVENT:
            begin
                cmd.apply_event = 1'b1;
                state_next      = S_LIMIT;
            end
            S_LIMIT:
            begin
                cmd.load_limit = 1'b1;
                state_next     = S_EMIT;
            end
            S_EMIT:
            begin
                if (sts.slot_free)
                begin
                    if (sts.skip || !sts.has_send)
                    begin
                        cmd.emit_status = 1'b1;
                        state_next      = S_IDLE;
                    end
                    else
                    begin
                        cmd.emit_send = 1'b1;
                        if (sts.last_send)
                        begin
                            state_next = S_IDLE;
                        end
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

### src/gbn_datapath.sv
// Window state, configuration registers and output register of the go-back-n sender.
`timescale 1ns / 1ps

module gbn_datapath #(
    parameter int WINDOW_MAX = gbn_pkg::WINDOW_MAX_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [gbn_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [gbn_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic [gbn_pkg::OP_W-1:0]        in_op,
    input  logic [gbn_pkg::SEQ_W-1:0]       in_ack,
    input  gbn_pkg::cmd_t                   cmd,
    output gbn_pkg::dp_status_t             sts,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [gbn_pkg::OUT_DATA_W-1:0]  m_tdata,
    output logic                            m_tuser,
    output logic                            m_tlast
);
    import gbn_pkg::*;

    localparam int CntW = $clog2(WINDOW_MAX + 1);

    logic [WIN_W-1:0]   win_cfg_reg;
    logic [PKT_W-1:0]   pkt_cfg_reg;
    logic [RETRY_W-1:0] retry_cfg_reg;

    logic [OP_W-1:0]    op_reg;
    logic [SEQ_W-1:0]   ack_reg;
    logic [BASE_W-1:0]  base_reg;
    logic [BASE_W-1:0]  base_next;
    logic [BASE_W-1:0]  next_reg;
    logic [BASE_W-1:0]  next_next;
    logic [RETRY_W-1:0] retry_reg;
    logic [RETRY_W-1:0] retry_next;
    logic               aborted_reg;
    logic               aborted_next;
    logic               skip_reg;
    logic               skip_next;
    logic [BASE_W-1:0]  limit_reg;
    logic [CntW-1:0]    cnt_reg;

    logic               m_valid_reg;
    logic [SEQ_W-1:0]   seq_out_reg;
    logic [BASE_W-1:0]  pay_out_reg;
    logic [BASE_W-1:0]  base_out_reg;
    logic [STAT_W-1:0]  stat_out_reg;
    logic               user_out_reg;
    logic               last_out_reg;

    logic               finished;
    logic [BASE_W-1:0]  ack_base;
    logic [RETRY_W-1:0] retry_inc;
    logic [BASE_W-1:0]  win_sat;
    logic [BASE_W:0]    limit_sum;
    logic [BASE_W-1:0]  limit_val;
    logic [BASE_W-1:0]  next_inc;
    logic [STAT_W-1:0]  cur_status;

    assign finished  = aborted_reg || (base_reg >= {1'b0, pkt_cfg_reg});
    assign ack_base  = {1'b0, ack_reg} + BASE_W'(1);
    assign retry_inc = (retry_reg == '1) ? retry_reg : retry_reg + RETRY_W'(1);
    assign win_sat   = (int'(win_cfg_reg) > WINDOW_MAX) ? BASE_W'(WINDOW_MAX)
                                                        : BASE_W'(win_cfg_reg);
    assign limit_sum = {1'b0, base_reg} + {1'b0, win_sat};
    assign limit_val = (limit_sum > (BASE_W + 1)'(pkt_cfg_reg)) ? BASE_W'(pkt_cfg_reg)
                                                                : limit_sum[BASE_W-1:0];
    assign next_inc  = next_reg + BASE_W'(1);

    always_comb
    begin
        if (aborted_reg)
        begin
            cur_status = ST_ABORTED;
        end
        else if (base_reg >= {1'b0, pkt_cfg_reg})
        begin
            cur_status = ST_DONE;
        end
        else
        begin
            cur_status = ST_RUNNING;
        end
    end

    always_comb
    begin
        base_next    = base_reg;
        next_next    = next_reg;
        retry_next   = retry_reg;
        aborted_next = aborted_reg;
        skip_next    = skip_reg;
        if (cmd.apply_event)
        begin
            skip_next = finished;
            if (!finished)
            begin
                case (op_reg)
                    OP_ACK:
                    begin
                        retry_next = '0;
                        if ({1'b0, ack_reg} >= base_reg)
                        begin
                            base_next = ack_base;
                            if (next_reg < ack_base)
                            begin
                                next_next = ack_base;
                            end
                        end
                    end
                    OP_TIMEOUT:
                    begin
                        retry_next = retry_inc;
                        if (retry_inc >= retry_cfg_reg)
                        begin
                            aborted_next = 1'b1;
                            skip_next    = 1'b1;
                        end
                        else
                        begin
                            next_next = base_reg;
                        end
                    end
                    default:
                    begin
                        next_next = next_reg;
                    end
                endcase
            end
        end
        else if (cmd.emit_send)
        begin
            next_next = next_inc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_cfg_reg   <= WINDOW_SIZE_RST;
            pkt_cfg_reg   <= PACKET_COUNT_RST;
            retry_cfg_reg <= MAX_RETRIES_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_WINDOW_SIZE:  win_cfg_reg   <= cfg_data[WIN_W-1:0];
                REG_PACKET_COUNT: pkt_cfg_reg   <= cfg_data[PKT_W-1:0];
                REG_MAX_RETRIES:  retry_cfg_reg <= cfg_data[RETRY_W-1:0];
                default:          win_cfg_reg   <= win_cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg    <= '0;
            next_reg    <= '0;
            retry_reg   <= '0;
            aborted_reg <= 1'b0;
            skip_reg    <= 1'b0;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            base_reg    <= base_next;
            next_reg    <= next_next;
            retry_reg   <= retry_next;
            aborted_reg <= aborted_next;
            skip_reg    <= skip_next;
            if (cmd.load_limit)
            begin
                cnt_reg <= '0;
            end
            else if (cmd.emit_send)
            begin
                cnt_reg <= cnt_reg + CntW'(1);
            end
            if (cmd.emit_send || cmd.emit_status)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch_in)
        begin
            op_reg  <= in_op;
            ack_reg <= in_ack;
        end
        if (cmd.load_limit)
        begin
            limit_reg <= limit_val;
        end
        if (cmd.emit_send)
        begin
            seq_out_reg  <= next_reg[SEQ_W-1:0];
            pay_out_reg  <= next_inc;
            base_out_reg <= base_reg;
            stat_out_reg <= cur_status;
            user_out_reg <= 1'b1;
            last_out_reg <= sts.last_send;
        end
        else if (cmd.emit_status)
        begin
            seq_out_reg  <= '0;
            pay_out_reg  <= '0;
            base_out_reg <= base_reg;
            stat_out_reg <= cur_status;
            user_out_reg <= 1'b0;
            last_out_reg <= 1'b1;
        end
    end

    assign sts.skip      = skip_reg;
    assign sts.has_send  = next_reg < limit_reg;
    assign sts.last_send = (next_inc >= limit_reg) || (cnt_reg == CntW'(WINDOW_MAX - 1));
    assign sts.slot_free = !m_valid_reg || m_tready;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(OUT_DATA_W - SEQ_W - 2 * BASE_W - STAT_W){1'b0}},
                       stat_out_reg, base_out_reg, pay_out_reg, seq_out_reg};
    assign m_tuser  = user_out_reg;
    assign m_tlast  = last_out_reg;

endmodule

### src/go_back_n_sender.sv
// Top level of the go-back-n sender: event sequencer plus window datapath.
//
// Input stream: one word per event; s_tuser holds the event kind (start,
// acknowledgement, timeout) and s_tdata the acknowledged sequence number.
// Output stream: one word per packet to send, or one status word when an
// event sends nothing; m_tlast marks the final word of an event and m_tuser
// tells a packet word from a status word.
// Configuration: window size, packet count and retry limit through
// cfg_we / cfg_index / cfg_data; write only while the block is idle.
// Sequence: an event is taken in S_IDLE, applied in S_EVENT, the window
// limit is settled in S_LIMIT, and then one word is loaded per cycle into
// the output register while the output slot is free (m_tready stalls it).
// Reset clears the window base, next sequence, retry count and abort flag
// and loads the configuration defaults (window 3, 5 packets, 5 retries).
// When m_tready is low the output register holds its word and the
// sequencer waits; no word is dropped. s_tready is high only between events.
`timescale 1ns / 1ps

module go_back_n_sender #(
    parameter int WINDOW_MAX = gbn_pkg::WINDOW_MAX_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [gbn_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [gbn_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [gbn_pkg::IN_DATA_W-1:0]   s_tdata,  // [15:0] ack_number
    input  logic [gbn_pkg::OP_W-1:0]        s_tuser,  // [1:0] operation
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [15:0] seq_number, [32:16] payload, [49:33] window_base, [51:50] status
    output logic [gbn_pkg::OUT_DATA_W-1:0]  m_tdata,
    output logic                            m_tuser,  // [0] send_valid
    output logic                            m_tlast
);
    import gbn_pkg::*;

    cmd_t       cmd;
    dp_status_t sts;

    gbn_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    gbn_datapath #(
        .WINDOW_MAX (WINDOW_MAX)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_op     (s_tuser),
        .in_ack    (s_tdata[SEQ_W-1:0]),
        .cmd       (cmd),
        .sts       (sts),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

### verif/go_back_n_sender_test.sv
// Self-checking testbench for the go-back-n sender: directed table, random phases, predictor.
`timescale 1ns / 1ps

module go_back_n_sender_test;

    import gbn_pkg::*;

    localparam int WINDOW_MAX  = WINDOW_MAX_DEF;
    localparam int CYCLE_LIMIT = 1500000;
    localparam int PHASES      = 7;
    localparam int PHASE_EVENTS = 40;

    typedef enum logic [1:0] {
        ROW_EVENT,
        ROW_WRITE,
        ROW_RANDOM
    } row_kind_t;

    typedef struct packed {
        row_kind_t          kind;
        op_t                op;
        logic [15:0]        value;
        cfg_index_t         target;
        logic               typed;
        logic [BASE_W-1:0]  base;
        status_code_t       status;
    } row_t;

    typedef struct packed {
        logic               send;
        logic [SEQ_W-1:0]   seq;
        logic [BASE_W-1:0]  payload;
        logic [BASE_W-1:0]  base;
        status_code_t       status;
        logic               last;
    } sent_word_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_DATA_W-1:0]   s_tdata = '0;  // [15:0] ack_number
    logic [OP_W-1:0]        s_tuser = '0;  // [1:0] operation
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    // [15:0] seq_number, [32:16] payload, [49:33] window_base, [51:50] status
    logic [OUT_DATA_W-1:0]  m_tdata;
    logic                   m_tuser;       // [0] send_valid
    logic                   m_tlast;

    // window state and register copies
    logic [BASE_W-1:0]      sent_base = '0;
    logic [BASE_W-1:0]      send_next = '0;
    logic [RETRY_W-1:0]     retries = '0;
    logic                   aborted = 1'b0;
    logic [WIN_W-1:0]       cfg_window = WINDOW_SIZE_RST;
    logic [PKT_W-1:0]       cfg_packets = PACKET_COUNT_RST;
    logic [RETRY_W-1:0]     cfg_retry_limit = MAX_RETRIES_RST;

    sent_word_t             pending_words[$];
    sent_word_t             want;
    int                     error_count = 0;
    int                     cycle_count = 0;
    bit                     steady = 1'b0;

    row_t plan [26] = '{
        '{ROW_EVENT,  OP_START,   16'd0,     REG_SPARE,        1'b0, 17'd0,  ST_RUNNING},
        '{ROW_EVENT,  OP_SPARE,   16'd0,     REG_SPARE,        1'b1, 17'd0,  ST_RUNNING},
        '{ROW_EVENT,  OP_ACK,     16'd0,     REG_SPARE,        1'b0, 17'd0,  ST_RUNNING},
        '{ROW_EVENT,  OP_ACK,     16'd0,     REG_SPARE,        1'b1, 17'd1,  ST_RUNNING},
        '{ROW_EVENT,  OP_TIMEOUT, 16'd0,     REG_SPARE,        1'b0, 17'd0,  ST_RUNNING},
        '{ROW_WRITE,  OP_START,   16'd0,     REG_WINDOW_SIZE,  1'b0, 17'd0,  ST_RUNNING},
        '{ROW_EVENT,  OP_START,   16'd0,     REG_SPARE,        1'b1, 17'd1,  ST_RUNNING},
        '{ROW_EVENT,  OP_TIMEOUT, 16'd0,     REG_SPARE,        1'b1, 17'd1,  ST_RUNNING},
        '{ROW_WRITE,  OP_START,   16'd31,    REG_WINDOW_SIZE,  1'b0, 17'd0,  ST_RUNNING},
        '{ROW_WRITE,  OP_START,   16'd40,    REG_PACKET_COUNT, 1'b0, 17'd0,  ST_RUNNING},
        '{ROW_EVENT,  OP_START,   16'd0,     REG_SPARE,        1'b0, 17'd0,  ST_RUNNING},
        '{ROW_EVENT,  OP_ACK,     16'd30,    REG_SPARE,        1'b0, 17'd0,  ST_RUNNING},
        '{ROW_EVENT,  OP_ACK,     16'd39,    REG_SPARE,        1'b1, 17'd40, ST_DONE},
        '{ROW_EVENT,  OP_TIMEOUT, 16'd0,     REG_SPARE,        1'b1, 17'd40, ST_DONE},
        '{ROW_WRITE,  OP_START,   16'd0,     REG_PACKET_COUNT, 1'b0, 17'd0,  ST_RUNNING},
        '{ROW_EVENT,  OP_START,   16'd0,     REG_SPARE,        1'b1, 17'd40, ST_DONE},
        '{ROW_WRITE,  OP_START,   16'hFFFF,  REG_PACKET_COUNT, 1'b0, 17'd0,  ST_RUNNING},
        '{ROW_WRITE,  OP_START,   16'd16,    REG_WINDOW_SIZE,  1'b0, 17'd0,  ST_RUNNING},
        '{ROW_EVENT,  OP_START,   16'd0,     REG_SPARE,        1'b0, 17'd0,  ST_RUNNING},
        '{ROW_EVENT,  OP_TIMEOUT, 16'd0,     REG_SPARE,        1'b0, 17'd0,  ST_RUNNING},
        '{ROW_RANDOM, OP_START,   16'd0,     REG_SPARE,        1'b0, 17'd0,  ST_RUNNING},
        '{ROW_WRITE,  OP_START,   16'd0,     REG_MAX_RETRIES,  1'b0, 17'd0,  ST_RUNNING},
        '{ROW_EVENT,  OP_START,   16'd0,     REG_SPARE,        1'b0, 17'd0,  ST_RUNNING},
        '{ROW_EVENT,  OP_TIMEOUT, 16'd0,     REG_SPARE,        1'b0, 17'd0,  ST_RUNNING},
        '{ROW_EVENT,  OP_ACK,     16'hFFFF,  REG_SPARE,        1'b0, 17'd0,  ST_RUNNING},
        '{ROW_EVENT,  OP_SPARE,   16'd0,     REG_SPARE,        1'b0, 17'd0,  ST_RUNNING}
    };

    go_back_n_sender u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic status_code_t run_state();
        if (aborted)
            return ST_ABORTED;
        if (sent_base >= {1'b0, cfg_packets})
            return ST_DONE;
        return ST_RUNNING;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic push_status(input bit keep);
        if (keep)
            pending_words.push_back('{1'b0, '0, '0, sent_base, run_state(), 1'b1});
    endtask

    // advance the window copy by one event and queue the words it sends
    task automatic apply_event(input op_t op, input logic [15:0] ack, input bit keep);
        logic [BASE_W-1:0] limit;
        int win;
        int n;
        if (aborted || sent_base >= {1'b0, cfg_packets})
        begin
            push_status(keep);
            return;
        end
        if (op == OP_ACK)
        begin
            retries = '0;
            if ({1'b0, ack} >= sent_base)
            begin
                sent_base = {1'b0, ack} + 17'd1;
                if (send_next < sent_base)
                    send_next = sent_base;
            end
        end
        else if (op == OP_TIMEOUT)
        begin
            if (retries != 8'hFF)
                retries = retries + 8'd1;
            if (retries >= cfg_retry_limit)
            begin
                aborted = 1'b1;
                push_status(keep);
                return;
            end
            send_next = sent_base;
        end
        win = (int'(cfg_window) > WINDOW_MAX) ? WINDOW_MAX : int'(cfg_window);
        limit = sent_base + BASE_W'(win);
        if (limit > {1'b0, cfg_packets})
            limit = {1'b0, cfg_packets};
        n = (send_next < limit) ? int'(limit - send_next) : 0;
        if (n > WINDOW_MAX)
            n = WINDOW_MAX;
        if (n == 0)
            push_status(keep);
        for (int i = 0; i < n; i++)
        begin
            if (keep)
                pending_words.push_back('{1'b1, send_next[SEQ_W-1:0], send_next + 17'd1,
                                          sent_base, ST_RUNNING, i == n - 1});
            send_next = send_next + 17'd1;
        end
    endtask

    task automatic offer_event(input op_t op, input logic [15:0] ack, input bit keep);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= ack;
        do
            @(posedge clk);
        while (!s_tready);
        apply_event(op, ack, keep);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_words.size() != 0)
            @(posedge clk);
    endtask

    // bits above the register width carry random junk
    task automatic write_register(input cfg_index_t idx, input logic [15:0] value);
        logic [15:0] data;
        data = 16'($urandom);
        drain();
        repeat (8) @(posedge clk);
        case (idx)
            REG_WINDOW_SIZE:
            begin
                data[WIN_W-1:0] = value[WIN_W-1:0];
                cfg_window = value[WIN_W-1:0];
            end
            REG_PACKET_COUNT:
            begin
                data = value;
                cfg_packets = value;
            end
            REG_MAX_RETRIES:
            begin
                data[RETRY_W-1:0] = value[RETRY_W-1:0];
                cfg_retry_limit = value[RETRY_W-1:0];
            end
            default: ;
        endcase
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic run_random_phases();
        int r;
        int q;
        int b;
        int nx;
        int ack;
        int pkts;
        op_t op;
        for (int p = 0; p < PHASES; p++)
        begin
            steady = 1'b0;
            if (p == 0)
                write_register(REG_WINDOW_SIZE, 16'd16);
            else if (p == 1)
                write_register(REG_WINDOW_SIZE, 16'd1);
            else if (p == 2)
                write_register(REG_WINDOW_SIZE, 16'($urandom_range(17, 31)));
            else
                write_register(REG_WINDOW_SIZE, 16'($urandom_range(1, 16)));
            pkts = int'(sent_base) + $urandom_range(40, 300);
            if (pkts > 65535)
                pkts = 65535;
            write_register(REG_PACKET_COUNT, 16'(pkts));
            if (p == 0)
                write_register(REG_MAX_RETRIES, 16'd255);
            else if (p == 1)
                write_register(REG_MAX_RETRIES, 16'd1);
            else
                write_register(REG_MAX_RETRIES, 16'($urandom_range(2, 8)));
            steady = (p % 3 == 1);
            for (int e = 0; e < PHASE_EVENTS; e++)
            begin
                r = $urandom_range(0, 99);
                ack = 0;
                b = int'(sent_base);
                nx = int'(send_next);
                if (r < 12)
                    op = OP_START;
                else if (r < 17)
                    op = OP_SPARE;
                else if (r < 42 && int'(retries) + 1 < int'(cfg_retry_limit))
                    op = OP_TIMEOUT;
                else
                begin
                    op = OP_ACK;
                    q = $urandom_range(0, 9);
                    if (q < 6 && nx > b)
                        ack = $urandom_range(b, nx - 1);
                    else if (q < 8 && b > 0)
                        ack = $urandom_range(0, b - 1);
                    else
                        ack = nx + $urandom_range(0, 20);
                    if (ack > 65534)
                        ack = 65534;
                end
                if (op != OP_ACK)
                    ack = $urandom_range(0, 65535);
                offer_event(op, 16'(ack), 1'b1);
            end
        end
        steady = 1'b0;
    endtask

    task automatic check_field(input string name, input longint unsigned exp_val,
                               input longint unsigned act_val);
        if (exp_val != act_val)
        begin
            error_count++;
            $display("%0t: %s expected %0h actual %0h", $time, name, exp_val, act_val);
        end
    endtask

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin : rx_stall
        int hold;
        hold = 0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (hold > 0)
            begin
                m_tready <= 1'b0;
                hold--;
            end
            else
            begin
                m_tready <= 1'b1;
                if (!steady && $urandom_range(0, 4) == 0)
                    hold = pick_gap();
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_words.size() == 0)
            begin
                error_count++;
                $display("%0t: word with nothing expected, expected none actual tdata=%h",
                         $time, m_tdata);
            end
            else
            begin
                want = pending_words.pop_front();
                check_field("send_valid", want.send, m_tuser);
                check_field("seq_number", want.seq, m_tdata[15:0]);
                check_field("payload", want.payload, m_tdata[32:16]);
                check_field("window_base", want.base, m_tdata[49:33]);
                check_field("status", want.status, m_tdata[51:50]);
                check_field("last", want.last, m_tlast);
                check_field("tdata pad", 0, m_tdata[55:52]);
            end
        end
    end

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (plan[k])
        begin
            case (plan[k].kind)
                ROW_WRITE:
                    write_register(plan[k].target, plan[k].value);
                ROW_RANDOM:
                    run_random_phases();
                default:
                begin
                    offer_event(plan[k].op, plan[k].value, !plan[k].typed);
                    if (plan[k].typed)
                        pending_words.push_back('{1'b0, '0, '0, plan[k].base,
                                                  plan[k].status, 1'b1});
                end
            endcase
        end
        drain();
        repeat (30) @(posedge clk);
        if (error_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

### filelist.f
src/gbn_pkg.sv
src/gbn_ctrl.sv
src/gbn_datapath.sv
src/go_back_n_sender.sv
verif/go_back_n_sender_test.sv
